>>> hdl/cbia_pkg.sv
// shared types, widths, opcodes and arithmetic helpers of the complex box interval alu
package cbia_pkg;

	// bound format
	localparam int VW = 24;
	localparam int FB = 16;
	localparam int KW = 3;
	// product, exact sum of two products, and rounded wide result
	localparam int PW = 2 * VW;
	localparam int SW = 2 * VW + 2;
	localparam int RW = (2 * VW + 1 - FB > VW + 2) ? 2 * VW + 1 - FB : VW + 2;
	localparam int NC = 16;
	// corner groups reduced in the first min/max stage
	localparam int NG = NC / 4;

	localparam logic [SW-1:0] HALF_UNIT = SW'(1) << (FB - 1);

	typedef enum logic [KW-1:0] {
		OP_ADD   = 3'd0,
		OP_MUL   = 3'd1,
		OP_JOIN  = 3'd2,
		OP_NEG   = 3'd3,
		OP_SCALE = 3'd4,
		OP_CONT  = 3'd5,
		OP_EQ    = 3'd6
	} op_t;

	typedef logic signed [VW-1:0] val_t;
	typedef logic signed [RW-1:0] wide_t;
	typedef logic signed [PW-1:0] prod_t;
	typedef logic signed [SW-1:0] sum_t;
	typedef prod_t prod_grid_t [2][2];
	typedef wide_t corner_t [NC];

	typedef struct {
		val_t rl;
		val_t rh;
		val_t il;
		val_t ih;
	} box_t;

	typedef struct {
		wide_t rl;
		wide_t rh;
		wide_t il;
		wide_t ih;
	} wbox_t;

	typedef struct packed {
		op_t  op;
		logic f_neg;
		logic truth;
	} ctl_t;

	// sign extend a bound to the wide result format
	function automatic wide_t ext_v(val_t v);
		return {{(RW - VW){v[VW-1]}}, v};
	endfunction

	// sign extend a product to the exact sum format
	function automatic sum_t ext_p(prod_t p);
		return {{(SW - PW){p[PW-1]}}, p};
	endfunction

	// round to nearest with ties upward, drop the fraction bits
	function automatic wide_t round_fix(sum_t s);
		sum_t t;
		sum_t sh;
		t  = s + $signed(HALF_UNIT);
		sh = t >>> FB;
		return sh[RW-1:0];
	endfunction

	function automatic wide_t wmin(wide_t x, wide_t y);
		return (x < y) ? x : y;
	endfunction

	function automatic wide_t wmax(wide_t x, wide_t y);
		return (x > y) ? x : y;
	endfunction

	// wide value does not fit in a bound
	function automatic logic sat_ovf(wide_t v);
		return !((&v[RW-1:VW-1]) || !(|v[RW-1:VW-1]));
	endfunction

	function automatic val_t sat_val(wide_t v);
		if (sat_ovf(v)) begin
			return v[RW-1] ? {1'b1, {(VW - 1){1'b0}}} : {1'b0, {(VW - 1){1'b1}}};
		end
		return v[VW-1:0];
	endfunction

endpackage

>>> hdl/cbia_in_if.sv
// operand word channel: opcode and two boxes
interface cbia_in_if;
	import cbia_pkg::*;

	logic            valid;
	logic            ready;
	logic [KW-1:0]   kind;
	val_t            a_re_lo;
	val_t            a_re_hi;
	val_t            a_im_lo;
	val_t            a_im_hi;
	val_t            b_re_lo;
	val_t            b_re_hi;
	val_t            b_im_lo;
	val_t            b_im_hi;

	modport source (
		output valid, kind, a_re_lo, a_re_hi, a_im_lo, a_im_hi,
		       b_re_lo, b_re_hi, b_im_lo, b_im_hi,
		input  ready
	);

	modport sink (
		input  valid, kind, a_re_lo, a_re_hi, a_im_lo, a_im_hi,
		       b_re_lo, b_re_hi, b_im_lo, b_im_hi,
		output ready
	);
endinterface

>>> hdl/cbia_out_if.sv
// result word channel: result box, truth and overflow flags
interface cbia_out_if;
	import cbia_pkg::*;

	logic valid;
	logic ready;
	val_t r_re_lo;
	val_t r_re_hi;
	val_t r_im_lo;
	val_t r_im_hi;
	logic truth;
	logic overflow;

	modport source (
		output valid, r_re_lo, r_re_hi, r_im_lo, r_im_hi, truth, overflow,
		input  ready
	);

	modport sink (
		input  valid, r_re_lo, r_re_hi, r_im_lo, r_im_hi, truth, overflow,
		output ready
	);
endinterface

>>> hdl/complex_box_interval_alu_unit.sv
// top level of the complex box interval alu: ordering stage, pipeline control, ports
//
// Five-stage pipeline: a new word can be taken in every cycle as long as rsp is not held,
// so sustained throughput is one word per clock while the result side keeps taking words.
// Stage 1 orders both boxes, stage 2 runs sixteen 24x24 signed multipliers (every corner
// product of the two boxes) next to add, join, negate, contains and equal, stage 3 forms
// and rounds the real and imaginary part of each corner, and stages 4 and 5 reduce the
// corners through a min/max tree, then pick and saturate the result. Each stage has its
// own valid bit and only stalls when the stage after it is full and held, so bubbles
// close up and a stalled rsp still leaves room for up to four more words inside.
module complex_box_interval_alu_unit (
	input logic       clk,
	input logic       arst_n,
	cbia_in_if.sink   req,
	cbia_out_if.source rsp
);
	import cbia_pkg::*;

	logic       v1_s1, v2_s2, v3_s3, v4_s4, v5_s5;
	logic       en1, en2, en3, en4, en5;

	op_t        op_in;
	box_t       a_ord;
	box_t       b_ord;
	ctl_t       ctl_d;

	box_t       a_s1;
	box_t       b_s1;
	ctl_t       ctl_s1;

	prod_grid_t prr, pii, pri, pir;
	wbox_t      simp2, simp3, sc3;
	ctl_t       ctl2, ctl3;
	corner_t    re3, im3;
	box_t       rbox;

	// each stage moves when it is empty or the next stage moves
	assign en5       = !v5_s5 || rsp.ready;
	assign en4       = !v4_s4 || en5;
	assign en3       = !v3_s3 || en4;
	assign en2       = !v2_s2 || en3;
	assign en1       = !v1_s1 || en2;
	assign req.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
			v4_s4 <= 1'b0;
			v5_s5 <= 1'b0;
		end else begin
			if (en1) v1_s1 <= req.valid;
			if (en2) v2_s2 <= v1_s1;
			if (en3) v3_s3 <= v2_s2;
			if (en4) v4_s4 <= v3_s3;
			if (en5) v5_s5 <= v4_s4;
		end
	end

	// order both boxes, b carries the factor or the point where the opcode says so
	always_comb begin
		op_in    = op_t'(req.kind);
		a_ord.rl = (req.a_re_lo < req.a_re_hi) ? req.a_re_lo : req.a_re_hi;
		a_ord.rh = (req.a_re_lo < req.a_re_hi) ? req.a_re_hi : req.a_re_lo;
		a_ord.il = (req.a_im_lo < req.a_im_hi) ? req.a_im_lo : req.a_im_hi;
		a_ord.ih = (req.a_im_lo < req.a_im_hi) ? req.a_im_hi : req.a_im_lo;
		b_ord.rl = (req.b_re_lo < req.b_re_hi) ? req.b_re_lo : req.b_re_hi;
		b_ord.rh = (req.b_re_lo < req.b_re_hi) ? req.b_re_hi : req.b_re_lo;
		b_ord.il = (req.b_im_lo < req.b_im_hi) ? req.b_im_lo : req.b_im_hi;
		b_ord.ih = (req.b_im_lo < req.b_im_hi) ? req.b_im_hi : req.b_im_lo;
		if (op_in == OP_SCALE) begin
			b_ord.rl = req.b_re_lo;
			b_ord.rh = req.b_re_lo;
		end else if (op_in == OP_CONT) begin
			b_ord.rl = req.b_re_lo;
			b_ord.il = req.b_im_lo;
		end
		ctl_d.op    = op_in;
		ctl_d.f_neg = req.b_re_lo[VW-1];
		ctl_d.truth = 1'b0;
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			a_s1   <= a_ord;
			b_s1   <= b_ord;
			ctl_s1 <= ctl_d;
		end
	end

	cbia_mult u_mult (
		.clk     (clk),
		.en      (en2),
		.a       (a_s1),
		.b       (b_s1),
		.ctl_in  (ctl_s1),
		.prr     (prr),
		.pii     (pii),
		.pri     (pri),
		.pir     (pir),
		.simp    (simp2),
		.ctl_out (ctl2)
	);

	cbia_round u_round (
		.clk      (clk),
		.en       (en3),
		.prr      (prr),
		.pii      (pii),
		.pri      (pri),
		.pir      (pir),
		.simp_in  (simp2),
		.ctl_in   (ctl2),
		.re       (re3),
		.im       (im3),
		.sc       (sc3),
		.simp_out (simp3),
		.ctl_out  (ctl3)
	);

	cbia_reduce u_reduce (
		.clk      (clk),
		.en4      (en4),
		.en5      (en5),
		.re       (re3),
		.im       (im3),
		.sc       (sc3),
		.simp     (simp3),
		.ctl_in   (ctl3),
		.rbox     (rbox),
		.truth    (rsp.truth),
		.overflow (rsp.overflow)
	);

	// result word
	assign rsp.valid   = v5_s5;
	assign rsp.r_re_lo = rbox.rl;
	assign rsp.r_re_hi = rbox.rh;
	assign rsp.r_im_lo = rbox.il;
	assign rsp.r_im_hi = rbox.ih;

	// input only backs up when every stage is full and the output is held
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> (v1_s1 && v2_s2 && v3_s3 && v4_s4 && v5_s5 && !rsp.ready))
		else $error("input stalled with room in the pipeline");

	// an accepted word lands in stage 1
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> v1_s1)
		else $error("accepted word lost at stage 1");

	// a held stage keeps its word
	a_stage4_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(v4_s4 && !en4) |=> v4_s4)
		else $error("stalled word dropped from stage 4");

	// a true answer comes with a zero box and no overflow
	a_truth_box: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.truth) |-> (rsp.r_re_lo == '0 && rsp.r_re_hi == '0 &&
		rsp.r_im_lo == '0 && rsp.r_im_hi == '0 && !rsp.overflow))
		else $error("truth answer with nonzero box or overflow");
endmodule

>>> hdl/cbia_mult.sv
// stage 2: sixteen corner multipliers plus the add, join, negate, contains and equal operations
module cbia_mult (
	input  logic                clk,
	input  logic                en,
	input  cbia_pkg::box_t      a,
	input  cbia_pkg::box_t      b,
	input  cbia_pkg::ctl_t      ctl_in,
	output cbia_pkg::prod_grid_t prr,
	output cbia_pkg::prod_grid_t pii,
	output cbia_pkg::prod_grid_t pri,
	output cbia_pkg::prod_grid_t pir,
	output cbia_pkg::wbox_t     simp,
	output cbia_pkg::ctl_t      ctl_out
);
	import cbia_pkg::*;

	val_t       ar [2];
	val_t       ai [2];
	val_t       br [2];
	val_t       bi [2];
	wbox_t      simp_d;
	logic       truth_d;
	ctl_t       ctl_d;

	prod_grid_t prr_s2;
	prod_grid_t pii_s2;
	prod_grid_t pri_s2;
	prod_grid_t pir_s2;
	wbox_t      simp_s2;
	ctl_t       ctl_s2;

	// corner coordinates, index 0 is the lower bound
	always_comb begin
		ar[0] = a.rl;
		ar[1] = a.rh;
		ai[0] = a.il;
		ai[1] = a.ih;
		br[0] = b.rl;
		br[1] = b.rh;
		bi[0] = b.il;
		bi[1] = b.ih;
	end

	// add, join and negate in wide format, truth for contains and equal
	always_comb begin
		simp_d  = '{rl: '0, rh: '0, il: '0, ih: '0};
		truth_d = 1'b0;
		unique case (ctl_in.op)
			OP_ADD: begin
				simp_d.rl = ext_v(a.rl) + ext_v(b.rl);
				simp_d.rh = ext_v(a.rh) + ext_v(b.rh);
				simp_d.il = ext_v(a.il) + ext_v(b.il);
				simp_d.ih = ext_v(a.ih) + ext_v(b.ih);
			end
			OP_JOIN: begin
				simp_d.rl = wmin(ext_v(a.rl), ext_v(b.rl));
				simp_d.rh = wmax(ext_v(a.rh), ext_v(b.rh));
				simp_d.il = wmin(ext_v(a.il), ext_v(b.il));
				simp_d.ih = wmax(ext_v(a.ih), ext_v(b.ih));
			end
			OP_NEG: begin
				simp_d.rl = -ext_v(a.rh);
				simp_d.rh = -ext_v(a.rl);
				simp_d.il = -ext_v(a.ih);
				simp_d.ih = -ext_v(a.il);
			end
			OP_CONT: begin
				truth_d = (a.rl <= b.rl) && (b.rl <= a.rh) &&
				          (a.il <= b.il) && (b.il <= a.ih);
			end
			OP_EQ: begin
				truth_d = (a.rl == b.rl) && (a.rh == b.rh) &&
				          (a.il == b.il) && (a.ih == b.ih);
			end
			default: begin
				truth_d = 1'b0;
			end
		endcase
		ctl_d       = ctl_in;
		ctl_d.truth = truth_d;
	end

	// stage 2 registers, one product per multiplier
	always_ff @(posedge clk) begin
		if (en) begin
			for (int x = 0; x < 2; x++) begin
				for (int u = 0; u < 2; u++) begin
					prr_s2[x][u] <= ar[x] * br[u];
					pii_s2[x][u] <= ai[x] * bi[u];
					pri_s2[x][u] <= ar[x] * bi[u];
					pir_s2[x][u] <= ai[x] * br[u];
				end
			end
			simp_s2 <= simp_d;
			ctl_s2  <= ctl_d;
		end
	end

	assign prr     = prr_s2;
	assign pii     = pii_s2;
	assign pri     = pri_s2;
	assign pir     = pir_s2;
	assign simp    = simp_s2;
	assign ctl_out = ctl_s2;
endmodule

>>> hdl/cbia_round.sv
// stage 3: combine products into corner real and imaginary parts, round once
module cbia_round (
	input  logic                 clk,
	input  logic                 en,
	input  cbia_pkg::prod_grid_t prr,
	input  cbia_pkg::prod_grid_t pii,
	input  cbia_pkg::prod_grid_t pri,
	input  cbia_pkg::prod_grid_t pir,
	input  cbia_pkg::wbox_t      simp_in,
	input  cbia_pkg::ctl_t       ctl_in,
	output cbia_pkg::corner_t    re,
	output cbia_pkg::corner_t    im,
	output cbia_pkg::wbox_t      sc,
	output cbia_pkg::wbox_t      simp_out,
	output cbia_pkg::ctl_t       ctl_out
);
	import cbia_pkg::*;

	corner_t re_d;
	corner_t im_d;
	wbox_t   sc_d;

	corner_t re_s3;
	corner_t im_s3;
	wbox_t   sc_s3;
	wbox_t   simp_s3;
	ctl_t    ctl_s3;

	// corner k picks a.re by bit 0, a.im by bit 1, b.re by bit 2, b.im by bit 3
	always_comb begin
		logic [3:0] idx;
		idx = '0;
		for (int k = 0; k < NC; k++) begin
			idx     = 4'(k);
			re_d[k] = round_fix(ext_p(prr[idx[0]][idx[2]]) - ext_p(pii[idx[1]][idx[3]]));
			im_d[k] = round_fix(ext_p(pri[idx[0]][idx[3]]) + ext_p(pir[idx[1]][idx[2]]));
		end
	end

	// scale: b real bounds both carry the factor, so column 0 holds bound times factor
	always_comb begin
		sc_d.rl = round_fix(ext_p(prr[0][0]));
		sc_d.rh = round_fix(ext_p(prr[1][0]));
		sc_d.il = round_fix(ext_p(pir[0][0]));
		sc_d.ih = round_fix(ext_p(pir[1][0]));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			re_s3   <= re_d;
			im_s3   <= im_d;
			sc_s3   <= sc_d;
			simp_s3 <= simp_in;
			ctl_s3  <= ctl_in;
		end
	end

	assign re       = re_s3;
	assign im       = im_s3;
	assign sc       = sc_s3;
	assign simp_out = simp_s3;
	assign ctl_out  = ctl_s3;
endmodule

>>> hdl/cbia_reduce.sv
// stages 4 and 5: min/max tree over the corners, result select and saturation
module cbia_reduce (
	input  logic              clk,
	input  logic              en4,
	input  logic              en5,
	input  cbia_pkg::corner_t re,
	input  cbia_pkg::corner_t im,
	input  cbia_pkg::wbox_t   sc,
	input  cbia_pkg::wbox_t   simp,
	input  cbia_pkg::ctl_t    ctl_in,
	output cbia_pkg::box_t    rbox,
	output logic              truth,
	output logic              overflow
);
	import cbia_pkg::*;

	wbox_t grp_d   [NG];
	wbox_t grp_s4  [NG];
	wbox_t sc_s4;
	wbox_t simp_s4;
	ctl_t  ctl_s4;

	wbox_t mul_d;
	wbox_t sel_d;
	box_t  rbox_d;
	logic  ovf_d;

	box_t  rbox_s5;
	logic  truth_s5;
	logic  ovf_s5;

	// first two tree levels: groups of four corners
	always_comb begin
		for (int g = 0; g < NG; g++) begin
			grp_d[g].rl = wmin(wmin(re[4*g], re[4*g+1]), wmin(re[4*g+2], re[4*g+3]));
			grp_d[g].rh = wmax(wmax(re[4*g], re[4*g+1]), wmax(re[4*g+2], re[4*g+3]));
			grp_d[g].il = wmin(wmin(im[4*g], im[4*g+1]), wmin(im[4*g+2], im[4*g+3]));
			grp_d[g].ih = wmax(wmax(im[4*g], im[4*g+1]), wmax(im[4*g+2], im[4*g+3]));
		end
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			grp_s4  <= grp_d;
			sc_s4   <= sc;
			simp_s4 <= simp;
			ctl_s4  <= ctl_in;
		end
	end

	// last two tree levels over the group results
	always_comb begin
		mul_d.rl = wmin(wmin(grp_s4[0].rl, grp_s4[1].rl), wmin(grp_s4[2].rl, grp_s4[3].rl));
		mul_d.rh = wmax(wmax(grp_s4[0].rh, grp_s4[1].rh), wmax(grp_s4[2].rh, grp_s4[3].rh));
		mul_d.il = wmin(wmin(grp_s4[0].il, grp_s4[1].il), wmin(grp_s4[2].il, grp_s4[3].il));
		mul_d.ih = wmax(wmax(grp_s4[0].ih, grp_s4[1].ih), wmax(grp_s4[2].ih, grp_s4[3].ih));
	end

	// pick the result, negative factor swaps the scaled bounds
	always_comb begin
		unique case (ctl_s4.op)
			OP_MUL: begin
				sel_d = mul_d;
			end
			OP_SCALE: begin
				if (ctl_s4.f_neg) begin
					sel_d = '{rl: sc_s4.rh, rh: sc_s4.rl, il: sc_s4.ih, ih: sc_s4.il};
				end else begin
					sel_d = sc_s4;
				end
			end
			default: begin
				sel_d = simp_s4;
			end
		endcase
	end

	// saturate every bound
	always_comb begin
		rbox_d.rl = sat_val(sel_d.rl);
		rbox_d.rh = sat_val(sel_d.rh);
		rbox_d.il = sat_val(sel_d.il);
		rbox_d.ih = sat_val(sel_d.ih);
		ovf_d     = sat_ovf(sel_d.rl) || sat_ovf(sel_d.rh) ||
		            sat_ovf(sel_d.il) || sat_ovf(sel_d.ih);
	end

	always_ff @(posedge clk) begin
		if (en5) begin
			rbox_s5  <= rbox_d;
			truth_s5 <= ctl_s4.truth;
			ovf_s5   <= ovf_d;
		end
	end

	assign rbox     = rbox_s5;
	assign truth    = truth_s5;
	assign overflow = ovf_s5;
endmodule

>>> test/tb_top.sv
// testbench for complex_box_interval_alu_unit: scoreboard, stimulus, handshake drivers
`timescale 1ns / 1ps

module tb_top;
	import cbia_pkg::*;

	// codes and limits local to the bench
	localparam logic [KW-1:0] OP_NONE = 3'd7;
	localparam val_t V_MAX = {1'b0, {(VW - 1){1'b1}}};
	localparam val_t V_MIN = {1'b1, {(VW - 1){1'b0}}};
	localparam val_t ONE = val_t'(1 << FB);
	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_WORDS = 346;
	localparam int MAX_SHOWN = 30;

	typedef struct {
		logic [KW-1:0] kind;
		val_t a_re_lo;
		val_t a_re_hi;
		val_t a_im_lo;
		val_t a_im_hi;
		val_t b_re_lo;
		val_t b_re_hi;
		val_t b_im_lo;
		val_t b_im_hi;
	} op_word_t;

	typedef struct {
		val_t r_re_lo;
		val_t r_re_hi;
		val_t r_im_lo;
		val_t r_im_hi;
		logic truth;
		logic overflow;
	} box_result_t;

	// expected result boxes, predicted from each accepted word
	class box_ledger;
		box_result_t expected_q[$];
		int errors;
		int noted;
		int checked;

		function int pending();
			return expected_q.size();
		endfunction

		// round to nearest, ties upward, drop the fraction bits
		function longint round_q(longint s);
			return (s + (longint'(1) <<< (FB - 1))) >>> FB;
		endfunction

		function val_t clamp(longint v, inout logic ovf);
			longint hi_lim;
			longint lo_lim;
			hi_lim = (longint'(1) <<< (VW - 1)) - 1;
			lo_lim = -hi_lim - 1;
			if (v > hi_lim) begin
				ovf = 1'b1;
				return V_MAX;
			end
			if (v < lo_lim) begin
				ovf = 1'b1;
				return V_MIN;
			end
			return val_t'(v);
		endfunction

		function void order(val_t x, val_t y, output longint lo, output longint hi);
			lo = (x < y) ? longint'(x) : longint'(y);
			hi = (x < y) ? longint'(y) : longint'(x);
		endfunction

		// bounds kept as rl, rh, il, ih in that order
		function box_result_t evaluate(op_word_t w);
			longint a[4];
			longint b[4];
			longint ar[4];
			longint ai[4];
			longint br[4];
			longint bi[4];
			longint r[4];
			longint re;
			longint im;
			longint f;
			longint zr;
			longint zi;
			int i;
			int j;
			logic ovf;
			box_result_t res;
			order(w.a_re_lo, w.a_re_hi, a[0], a[1]);
			order(w.a_im_lo, w.a_im_hi, a[2], a[3]);
			order(w.b_re_lo, w.b_re_hi, b[0], b[1]);
			order(w.b_im_lo, w.b_im_hi, b[2], b[3]);
			r = '{default: 0};
			res.truth = 1'b0;
			ovf = 1'b0;
			case (w.kind)
				OP_ADD: begin
					for (i = 0; i < 4; i++) r[i] = a[i] + b[i];
				end
				OP_MUL: begin
					// every corner of A against every corner of B
					ar = '{a[0], a[1], a[0], a[1]};
					ai = '{a[2], a[3], a[3], a[2]};
					br = '{b[0], b[1], b[0], b[1]};
					bi = '{b[2], b[3], b[3], b[2]};
					for (i = 0; i < 4; i++) begin
						for (j = 0; j < 4; j++) begin
							re = round_q(ar[i] * br[j] - ai[i] * bi[j]);
							im = round_q(ar[i] * bi[j] + ai[i] * br[j]);
							if (i == 0 && j == 0) begin
								r = '{re, re, im, im};
							end else begin
								if (re < r[0]) r[0] = re;
								if (re > r[1]) r[1] = re;
								if (im < r[2]) r[2] = im;
								if (im > r[3]) r[3] = im;
							end
						end
					end
				end
				OP_JOIN: begin
					r[0] = (a[0] < b[0]) ? a[0] : b[0];
					r[1] = (a[1] > b[1]) ? a[1] : b[1];
					r[2] = (a[2] < b[2]) ? a[2] : b[2];
					r[3] = (a[3] > b[3]) ? a[3] : b[3];
				end
				OP_NEG: begin
					r = '{-a[1], -a[0], -a[3], -a[2]};
				end
				OP_SCALE: begin
					// negative factor swaps the bounds
					f = longint'(w.b_re_lo);
					if (f >= 0) begin
						r = '{round_q(a[0] * f), round_q(a[1] * f),
							round_q(a[2] * f), round_q(a[3] * f)};
					end else begin
						r = '{round_q(a[1] * f), round_q(a[0] * f),
							round_q(a[3] * f), round_q(a[2] * f)};
					end
				end
				OP_CONT: begin
					zr = longint'(w.b_re_lo);
					zi = longint'(w.b_im_lo);
					res.truth = (a[0] <= zr && zr <= a[1] && a[2] <= zi && zi <= a[3]);
				end
				OP_EQ: begin
					res.truth = (a[0] == b[0] && a[1] == b[1] && a[2] == b[2] && a[3] == b[3]);
				end
				default: begin
				end
			endcase
			res.r_re_lo = clamp(r[0], ovf);
			res.r_re_hi = clamp(r[1], ovf);
			res.r_im_lo = clamp(r[2], ovf);
			res.r_im_hi = clamp(r[3], ovf);
			res.overflow = ovf;
			return res;
		endfunction

		function void note(op_word_t w);
			expected_q.push_back(evaluate(w));
			noted++;
		endfunction

		task report(string msg);
			errors++;
			if (errors <= MAX_SHOWN) $display("tb_top: mismatch at %0t: %s", $time, msg);
		endtask

		task check(box_result_t got);
			box_result_t want;
			if (expected_q.size() == 0) begin
				report("result word with no operation outstanding");
				return;
			end
			want = expected_q.pop_front();
			checked++;
			if (got.r_re_lo !== want.r_re_lo)
				report($sformatf("result %0d r_re_lo %0d, want %0d", checked, got.r_re_lo,
					want.r_re_lo));
			if (got.r_re_hi !== want.r_re_hi)
				report($sformatf("result %0d r_re_hi %0d, want %0d", checked, got.r_re_hi,
					want.r_re_hi));
			if (got.r_im_lo !== want.r_im_lo)
				report($sformatf("result %0d r_im_lo %0d, want %0d", checked, got.r_im_lo,
					want.r_im_lo));
			if (got.r_im_hi !== want.r_im_hi)
				report($sformatf("result %0d r_im_hi %0d, want %0d", checked, got.r_im_hi,
					want.r_im_hi));
			if (got.truth !== want.truth)
				report($sformatf("result %0d truth %b, want %b", checked, got.truth, want.truth));
			if (got.overflow !== want.overflow)
				report($sformatf("result %0d overflow %b, want %b", checked, got.overflow,
					want.overflow));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	int send_idle_pct;
	int stall_pct;
	int hold_request;
	box_ledger ledger = new();

	cbia_in_if req();
	cbia_out_if rsp();

	complex_box_interval_alu_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	always #5 clk = ~clk;

	function automatic op_word_t word_of(logic [KW-1:0] k, val_t arl, val_t arh, val_t ail,
		val_t aih, val_t brl, val_t brh, val_t bil, val_t bih);
		op_word_t w;
		w.kind = k;
		w.a_re_lo = arl;
		w.a_re_hi = arh;
		w.a_im_lo = ail;
		w.a_im_hi = aih;
		w.b_re_lo = brl;
		w.b_re_hi = brh;
		w.b_im_lo = bil;
		w.b_im_hi = bih;
		return w;
	endfunction

	// bound within four units either way, so products rarely saturate
	function automatic val_t pick_moderate();
		return val_t'(int'($urandom_range(0, 8 << FB)) - (4 << FB));
	endfunction

	function automatic val_t pick_bound();
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 4))
					0: return V_MIN;
					1: return V_MAX;
					2: return val_t'(0);
					3: return val_t'(-1);
					default: return val_t'(1);
				endcase
			end
			1, 2, 3: return val_t'($urandom);
			4, 5, 6, 7: return pick_moderate();
			default: return val_t'(int'($urandom_range(0, 600)) - 300);
		endcase
	endfunction

	// point inside an interval, often on one of its ends
	function automatic val_t pick_inside(val_t x, val_t y);
		longint lo;
		longint hi;
		lo = (x < y) ? longint'(x) : longint'(y);
		hi = (x < y) ? longint'(y) : longint'(x);
		case ($urandom_range(0, 3))
			0: return val_t'(lo);
			1: return val_t'(hi);
			default: return val_t'(lo + longint'($urandom_range(0, int'(hi - lo))));
		endcase
	endfunction

	function automatic op_word_t make_random_word();
		op_word_t w;
		w = word_of(($urandom_range(0, 99) < 3) ? OP_NONE : 3'($urandom_range(0, 6)),
			pick_bound(), pick_bound(), pick_bound(), pick_bound(),
			pick_bound(), pick_bound(), pick_bound(), pick_bound());
		if ((w.kind == OP_MUL || w.kind == OP_SCALE) && $urandom_range(0, 9) < 7) begin
			w.a_re_lo = pick_moderate();
			w.a_re_hi = pick_moderate();
			w.a_im_lo = pick_moderate();
			w.a_im_hi = pick_moderate();
			w.b_re_lo = pick_moderate();
			w.b_re_hi = pick_moderate();
			w.b_im_lo = pick_moderate();
			w.b_im_hi = pick_moderate();
		end
		// equal: mostly a copy of A, bounds possibly given in reverse
		if (w.kind == OP_EQ && $urandom_range(0, 2) != 0) begin
			w.b_re_lo = $urandom_range(0, 1) ? w.a_re_lo : w.a_re_hi;
			w.b_re_hi = (w.b_re_lo == w.a_re_lo) ? w.a_re_hi : w.a_re_lo;
			w.b_im_lo = $urandom_range(0, 1) ? w.a_im_lo : w.a_im_hi;
			w.b_im_hi = (w.b_im_lo == w.a_im_lo) ? w.a_im_hi : w.a_im_lo;
			if ($urandom_range(0, 3) == 0) w.b_im_hi = w.b_im_hi ^ val_t'(1 << $urandom_range(0, 23));
		end
		// contains: mostly a point inside A
		if (w.kind == OP_CONT && $urandom_range(0, 3) != 0) begin
			w.b_re_lo = pick_inside(w.a_re_lo, w.a_re_hi);
			w.b_im_lo = pick_inside(w.a_im_lo, w.a_im_hi);
		end
		return w;
	endfunction

	// offer one operation word, return at the edge where it is taken
	task automatic offer_word(op_word_t w);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.kind <= w.kind;
		req.a_re_lo <= w.a_re_lo;
		req.a_re_hi <= w.a_re_hi;
		req.a_im_lo <= w.a_im_lo;
		req.a_im_hi <= w.a_im_hi;
		req.b_re_lo <= w.b_re_lo;
		req.b_re_hi <= w.b_re_hi;
		req.b_im_lo <= w.b_im_lo;
		req.b_im_hi <= w.b_im_hi;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		ledger.note(w);
	endtask

	// stop offering until every outstanding result has come back
	task automatic drain_results();
		req.valid <= 1'b0;
		while (ledger.pending() != 0) @(posedge clk);
	endtask

	// stimulus
	initial begin
		op_word_t directed_q[$];
		int phase;
		arst_n <= 1'b0;
		req.valid <= 1'b0;
		req.kind <= OP_ADD;
		req.a_re_lo <= '0;
		req.a_re_hi <= '0;
		req.a_im_lo <= '0;
		req.a_im_hi <= '0;
		req.b_re_lo <= '0;
		req.b_re_hi <= '0;
		req.b_im_lo <= '0;
		req.b_im_hi <= '0;
		send_idle_pct = 0;
		stall_pct = 0;
		hold_request = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// add: saturation both ways, then reversed bounds
		directed_q.push_back(word_of(OP_ADD, V_MAX, V_MAX, V_MIN, V_MIN, V_MAX, ONE, V_MIN, -ONE));
		directed_q.push_back(word_of(OP_ADD, val_t'(3 * ONE), -ONE, val_t'(ONE / 2),
			val_t'(2 * ONE), val_t'(-ONE / 4), ONE, val_t'(5 * ONE), val_t'(-2 * ONE)));
		// multiply: full scale, moderate, rounding ties, most negative corners
		directed_q.push_back(word_of(OP_MUL, V_MAX, V_MAX, V_MAX, V_MAX,
			V_MAX, V_MAX, V_MAX, V_MAX));
		directed_q.push_back(word_of(OP_MUL, -ONE, val_t'(2 * ONE), val_t'(ONE / 2),
			val_t'(-3 * ONE), ONE, val_t'(-ONE / 4), val_t'(3 * ONE / 2), val_t'(ONE / 8)));
		directed_q.push_back(word_of(OP_MUL, 1, 1, 0, 0, 32768, 32768, 0, 0));
		directed_q.push_back(word_of(OP_MUL, -1, -1, 0, 0, 32768, 32768, 0, 0));
		directed_q.push_back(word_of(OP_MUL, V_MIN, V_MAX, V_MIN, V_MAX,
			V_MIN, V_MIN, V_MAX, V_MAX));
		// join, one with every pair reversed
		directed_q.push_back(word_of(OP_JOIN, -ONE, ONE, 0, val_t'(2 * ONE), val_t'(ONE / 2),
			val_t'(3 * ONE), -ONE, ONE));
		directed_q.push_back(word_of(OP_JOIN, V_MAX, V_MIN, ONE, -ONE, 7, -7, V_MAX, 0));
		// negate: most negative bound saturates, B is ignored
		directed_q.push_back(word_of(OP_NEG, V_MIN, ONE, V_MIN, V_MIN, V_MAX, V_MIN, -1, 1));
		directed_q.push_back(word_of(OP_NEG, val_t'(2 * ONE), val_t'(-ONE / 2), 5, -5,
			123, -456, 789, -1));
		// scale: negative, zero, most negative factor, rounding tie
		directed_q.push_back(word_of(OP_SCALE, -ONE, val_t'(2 * ONE), ONE, val_t'(3 * ONE),
			val_t'(-ONE / 2), V_MAX, V_MIN, V_MAX));
		directed_q.push_back(word_of(OP_SCALE, V_MIN, V_MAX, -ONE, ONE, 0, ONE, ONE, ONE));
		directed_q.push_back(word_of(OP_SCALE, V_MIN, V_MAX, V_MIN, V_MAX, V_MIN, 0, 0, 0));
		directed_q.push_back(word_of(OP_SCALE, 1, -1, 3, -3, 32768, 0, 0, 0));
		// contains: inside, on a corner, outside, upper B fields ignored
		directed_q.push_back(word_of(OP_CONT, -ONE, ONE, -ONE, ONE, val_t'(ONE / 2), 0,
			val_t'(-ONE / 2), 0));
		directed_q.push_back(word_of(OP_CONT, ONE, -ONE, -ONE, ONE, ONE, 0, -ONE, 0));
		directed_q.push_back(word_of(OP_CONT, -ONE, ONE, -ONE, ONE, val_t'(ONE + 1), 0, 0, 0));
		directed_q.push_back(word_of(OP_CONT, V_MIN, V_MAX, V_MIN, V_MAX,
			V_MIN, V_MAX, V_MAX, V_MIN));
		// equal: identical, given reversed, one bound off
		directed_q.push_back(word_of(OP_EQ, -ONE, ONE, 2, 9, -ONE, ONE, 2, 9));
		directed_q.push_back(word_of(OP_EQ, ONE, -ONE, 9, 2, -ONE, ONE, 2, 9));
		directed_q.push_back(word_of(OP_EQ, -ONE, ONE, 2, 9, -ONE, ONE, 2, 10));
		// unused kind code gives an all-zero result
		directed_q.push_back(word_of(OP_NONE, V_MAX, V_MIN, V_MAX, V_MIN,
			V_MIN, V_MAX, V_MIN, V_MAX));
		directed_q.push_back(word_of(OP_NONE, -1, -1, -1, -1, -1, -1, -1, -1));
		foreach (directed_q[i]) offer_word(directed_q[i]);
		drain_results();

		// hold the output long enough for the pipeline to back up into the input
		hold_request = HOLD_CYCLES;
		repeat (40) offer_word(make_random_word());
		drain_results();

		// random words under each idle and stall mix
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0; stall_pct = 0; end
				1: begin send_idle_pct = 56; stall_pct = 0; end
				2: begin send_idle_pct = 0; stall_pct = 56; end
				default: begin send_idle_pct = 26; stall_pct = 26; end
			endcase
			repeat (PHASE_WORDS) offer_word(make_random_word());
			drain_results();
		end

		repeat (20) @(posedge clk);
		if (ledger.pending() != 0) ledger.report("results still outstanding at the end");
		$display("tb_top: %0d operation words sent, %0d result words checked, %0d mismatches",
			ledger.noted, ledger.checked, ledger.errors);
		$display("tb_top: covered all kind codes, saturation, rounding ties, four idle mixes, "
			, "a long output hold");
		if (ledger.errors == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: done, errors");
		end
		$finish;
	end

	// result side: random stalls plus a long hold on request
	initial begin
		box_result_t got;
		int hold_left;
		logic hold_taken;
		hold_left = 0;
		hold_taken = 1'b0;
		rsp.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (rsp.valid && rsp.ready) begin
				got.r_re_lo = rsp.r_re_lo;
				got.r_re_hi = rsp.r_re_hi;
				got.r_im_lo = rsp.r_im_lo;
				got.r_im_hi = rsp.r_im_hi;
				got.truth = rsp.truth;
				got.overflow = rsp.overflow;
				ledger.check(got);
			end
			if (hold_request != 0 && !hold_taken) begin
				hold_left = hold_request;
				hold_taken = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	// watchdog: too long without any word moving on either side
	initial begin
		int quiet;
		quiet = 0;
		wait (arst_n === 1'b1);
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet = 0;
			else quiet++;
		end
		$display("tb_top: no word moved for %0d cycles, %0d results outstanding",
			quiet, ledger.pending());
		$display("tb_top: done, errors");
		$finish;
	end

endmodule

>>> files.f
hdl/cbia_pkg.sv
hdl/cbia_in_if.sv
hdl/cbia_out_if.sv
hdl/cbia_mult.sv
hdl/cbia_round.sv
hdl/cbia_reduce.sv
hdl/complex_box_interval_alu_unit.sv
test/tb_top.sv
